// ----- rtl/msdc_pkg.sv -----
// Shared types and codes of the stride mesh decimator.
// Item and result structs, kind and status codes, controller states.
// No dependencies.
package msdc_pkg;

	localparam logic [1:0] KIND_VERTEX   = 2'd0;
	localparam logic [1:0] KIND_TRIANGLE = 2'd1;
	localparam logic [1:0] KIND_FINISH   = 2'd2;
	localparam logic [1:0] KIND_FETCH    = 2'd3;

	localparam logic [1:0] RK_VERTEX   = 2'd0;
	localparam logic [1:0] RK_TRIANGLE = 2'd1;
	localparam logic [1:0] RK_STATUS   = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;

	localparam logic [16:0] RATIO_ONE = 17'h10000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] coord_x;
		logic [31:0] coord_y;
		logic [31:0] coord_z;
		logic [31:0] index_a;
		logic [31:0] index_b;
		logic [31:0] index_c;
	} item_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
		logic [11:0] out_a;
		logic [11:0] out_b;
		logic [11:0] out_c;
		logic        last;
		logic [1:0]  status;
		logic [12:0] kept_vertices;
		logic [12:0] kept_triangles;
	} result_t;

	typedef enum logic [1:0] {
		PH_LOADING,
		PH_DONE
	} phase_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_MUL,
		S_DIVGO,
		S_DIV,
		S_WALK_RD,
		S_WALK_CHK,
		S_MARK_B,
		S_MARK_C,
		S_REMAP,
		S_VTX,
		S_TRI,
		S_MAP_A,
		S_MAP_B,
		S_MAP_C,
		S_EMIT
	} state_t;

endpackage

// ----- rtl/msdc_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// Used once per decimating finish to derive the triangle stride. No package use.
module msdc_divider #(
	parameter int W = 13
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CW = $clog2(W + 1);

	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;

	assign shifted  = {rem_q[W-1:0], quo_q[W-1]};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (shifted >= {1'b0, divisor}) begin
				rem_q <= shifted - {1'b0, divisor};
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

endmodule

// ----- rtl/mesh_stride_decimate_compact.sv -----
// Top level of the stride mesh decimator: controller and mesh memories.
// Depends on msdc_pkg and msdc_divider.
//
// Usage. Items arrive on item/item_valid/item_stall, results leave on
// result/result_valid/result_stall; a transaction completes when valid is
// high and stall is low. keep_ratio is written on cfg_valid/cfg_data
// (cfg_ready is always high); the user writes it only while the block is idle, which the block does not enforce.
// Item handling, one item at a time:
//   vertex or triangle load: written to memory, no result.
//   fetch of a vertex: memory read, emit to the result register.
//   fetch of a triangle: triangle read, three remap reads, emit.
//   empty fetch or repeated finish: straight to emit.
//   finish: used-map clear over the V loaded vertices, ratio multiply,
//     stride divider, a walk over the T loaded triangles at the stride
//     that marks the vertices of each kept triangle, compaction over V,
//     emit. The used-map clear pass is the per-mesh clear of that memory.
// The vertex, triangle, used and remap memories each have one write and
// one registered read port; that sets the steps above.
// Reset: counters zero, phase loading, keep_ratio 65536; memory contents
// are not cleared. When the receiver stalls, the result register holds
// its transaction; loads pass until a pending result stalls all items.
module mesh_stride_decimate_compact #(
	parameter int MAX_VERTICES  = 4096,
	parameter int MAX_TRIANGLES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  msdc_pkg::item_t  item,
	output logic             result_valid,
	input  logic             result_stall,
	output msdc_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [16:0]      cfg_data
);

	localparam int VA  = $clog2(MAX_VERTICES);
	localparam int TA  = $clog2(MAX_TRIANGLES);
	localparam int VCW = $clog2(MAX_VERTICES + 1);
	localparam int TCW = $clog2(MAX_TRIANGLES + 1);
	localparam int PW  = $clog2(MAX_VERTICES + MAX_TRIANGLES + 1);
	localparam int FW  = VA + 1;
	localparam int TEW = 3 * FW;

	// mesh memories
	logic [95:0]  vmem [MAX_VERTICES];
	logic [TEW-1:0] tmem [MAX_TRIANGLES];
	logic         umem [MAX_VERTICES];
	logic [VA-1:0] rmem [MAX_VERTICES];

	logic         vwe, twe, uwe, rwe;
	logic [VA-1:0] vwa, vra, uwa, ura, rwa, rra;
	logic [TA-1:0] twa, tra;
	logic [95:0]  vwd, vrd_q;
	logic [TEW-1:0] twd, trd_q;
	logic         uwd, urd_q;
	logic [VA-1:0] rwd, rrd_q;

	always_ff @(posedge clk) begin
		if (vwe) vmem[vwa] <= vwd;
		vrd_q <= vmem[vra];
	end
	always_ff @(posedge clk) begin
		if (twe) tmem[twa] <= twd;
		trd_q <= tmem[tra];
	end
	always_ff @(posedge clk) begin
		if (uwe) umem[uwa] <= uwd;
		urd_q <= umem[ura];
	end
	always_ff @(posedge clk) begin
		if (rwe) rmem[rwa] <= rwd;
		rrd_q <= rmem[rra];
	end

	// control state
	msdc_pkg::state_t state_q, state_d;
	msdc_pkg::phase_t phase_q, phase_d;
	logic [VCW-1:0] vt_q, vt_d, kv_q, kv_d, v_q, v_d;
	logic [TCW-1:0] tt_q, tt_d, kt_q, kt_d;
	logic [TCW:0]   i_q, i_d;
	logic [PW-1:0]  rp_q, rp_d;
	logic           ovf_q, ovf_d;
	logic [16:0]    ratio_q;
	logic           rm_vld_s1, rm_vld_d;
	logic [VA-1:0]  rm_v_s1;
	logic           out_valid_q;
	msdc_pkg::result_t out_q;

	// payload registers
	msdc_pkg::result_t pend_q, pend_d;
	logic [TEW-1:0] tri_q, tri_d;
	logic [TCW-1:0] target_q, target_d, step_q, step_d;

	logic           accept, out_load, div_start, div_done;
	logic [TCW-1:0] div_q;
	logic [16:0]    r_sat;
	logic [TCW+16:0] prod;
	logic [TCW:0]   tgt_w;
	logic [PW-1:0]  total_w, last_w;
	logic           in_range;
	logic [VCW-1:0] cur_vt;
	logic [TCW-1:0] cur_tt;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != msdc_pkg::S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign out_load     = (state_q == msdc_pkg::S_EMIT) && (!out_valid_q || !result_stall);

	assign r_sat   = ratio_q[16] ? msdc_pkg::RATIO_ONE : ratio_q;
	assign prod    = (TCW+17)'(tt_q) * (TCW+17)'(r_sat);
	assign tgt_w   = prod[TCW+16:16];
	assign total_w = PW'(kv_q) + PW'(kt_q);
	assign last_w  = rp_q + PW'(1);

	// all three indices of the read triangle below the vertex count
	always_comb begin
		in_range = 1'b1;
		for (int j = 0; j < 3; j++) begin
			if (trd_q[j*FW+VA] || (VCW'(trd_q[j*FW +: VA]) >= vt_q))
				in_range = 1'b0;
		end
	end

	msdc_divider #(.W(TCW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (tt_q),
		.divisor  (target_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		vt_d      = vt_q;
		tt_d      = tt_q;
		kv_d      = kv_q;
		kt_d      = kt_q;
		v_d       = v_q;
		i_d       = i_q;
		rp_d      = rp_q;
		ovf_d     = ovf_q;
		rm_vld_d  = 1'b0;
		pend_d    = pend_q;
		tri_d     = tri_q;
		target_d  = target_q;
		step_d    = step_q;
		div_start = 1'b0;
		cur_vt    = vt_q;
		cur_tt    = tt_q;
		vwe = 1'b0; vwa = '0; vwd = '0; vra = '0;
		twe = 1'b0; twa = '0; twd = '0; tra = '0;
		uwe = 1'b0; uwa = '0; uwd = 1'b0; ura = '0;
		rwe = 1'b0; rwa = '0; rwd = '0; rra = '0;

		case (state_q)
			msdc_pkg::S_IDLE: begin
				if (accept) begin
					case (item.kind)
						msdc_pkg::KIND_VERTEX, msdc_pkg::KIND_TRIANGLE: begin
							// a load after finish opens a new mesh
							if (phase_q == msdc_pkg::PH_DONE) begin
								cur_vt  = '0;
								cur_tt  = '0;
								kv_d    = '0;
								kt_d    = '0;
								rp_d    = '0;
								ovf_d   = 1'b0;
								phase_d = msdc_pkg::PH_LOADING;
								vt_d    = '0;
								tt_d    = '0;
							end
							if (item.kind == msdc_pkg::KIND_VERTEX) begin
								if (cur_vt >= VCW'(MAX_VERTICES)) begin
									ovf_d = 1'b1;
								end else begin
									vwe  = 1'b1;
									vwa  = cur_vt[VA-1:0];
									vwd  = {item.coord_x, item.coord_y, item.coord_z};
									vt_d = cur_vt + VCW'(1);
								end
							end else begin
								if (cur_tt >= TCW'(MAX_TRIANGLES)) begin
									ovf_d = 1'b1;
								end else begin
									twe  = 1'b1;
									twa  = cur_tt[TA-1:0];
									twd  = {|item.index_c[31:VA], item.index_c[VA-1:0],
										|item.index_b[31:VA], item.index_b[VA-1:0],
										|item.index_a[31:VA], item.index_a[VA-1:0]};
									tt_d = cur_tt + TCW'(1);
								end
							end
						end
						msdc_pkg::KIND_FINISH: begin
							if (phase_q == msdc_pkg::PH_LOADING) begin
								v_d     = '0;
								kv_d    = '0;
								kt_d    = '0;
								state_d = msdc_pkg::S_CLEAR;
							end else begin
								rp_d    = '0;
								pend_d  = '0;
								pend_d.out_kind       = msdc_pkg::RK_STATUS;
								pend_d.status         = ovf_q ? msdc_pkg::STAT_OVERFLOW
									: msdc_pkg::STAT_OK;
								pend_d.kept_vertices  = 13'(kv_q);
								pend_d.kept_triangles = 13'(kt_q);
								state_d = msdc_pkg::S_EMIT;
							end
						end
						default: begin
							pend_d = '0;
							if (phase_q != msdc_pkg::PH_DONE || rp_q >= total_w) begin
								pend_d.out_kind = msdc_pkg::RK_STATUS;
								pend_d.status   = msdc_pkg::STAT_EMPTY;
								state_d = msdc_pkg::S_EMIT;
							end else if (rp_q < PW'(kv_q)) begin
								vra     = rp_q[VA-1:0];
								state_d = msdc_pkg::S_VTX;
							end else begin
								tra     = TA'(rp_q - PW'(kv_q));
								state_d = msdc_pkg::S_TRI;
							end
						end
					endcase
				end
			end
			msdc_pkg::S_CLEAR: begin
				if (v_q < vt_q) begin
					uwe = 1'b1;
					uwa = v_q[VA-1:0];
					v_d = v_q + VCW'(1);
				end else begin
					state_d = msdc_pkg::S_MUL;
				end
			end
			msdc_pkg::S_MUL: begin
				target_d = (tgt_w == '0) ? TCW'(1) : TCW'(tgt_w);
				state_d  = msdc_pkg::S_DIVGO;
			end
			msdc_pkg::S_DIVGO: begin
				div_start = 1'b1;
				state_d   = msdc_pkg::S_DIV;
			end
			msdc_pkg::S_DIV: begin
				if (div_done) begin
					step_d  = (div_q == '0) ? TCW'(1) : div_q;
					i_d     = '0;
					state_d = msdc_pkg::S_WALK_RD;
				end
			end
			msdc_pkg::S_WALK_RD: begin
				if (i_q < (TCW+1)'(tt_q)) begin
					tra     = i_q[TA-1:0];
					state_d = msdc_pkg::S_WALK_CHK;
				end else begin
					v_d     = '0;
					state_d = msdc_pkg::S_REMAP;
				end
			end
			msdc_pkg::S_WALK_CHK: begin
				if (in_range) begin
					// compact in place: kept count never passes the walk index
					uwe     = 1'b1;
					uwa     = trd_q[0 +: VA];
					uwd     = 1'b1;
					twe     = 1'b1;
					twa     = kt_q[TA-1:0];
					twd     = trd_q;
					kt_d    = kt_q + TCW'(1);
					tri_d   = trd_q;
					state_d = msdc_pkg::S_MARK_B;
				end else begin
					i_d     = i_q + (TCW+1)'(step_q);
					state_d = msdc_pkg::S_WALK_RD;
				end
			end
			msdc_pkg::S_MARK_B: begin
				uwe     = 1'b1;
				uwa     = tri_q[FW +: VA];
				uwd     = 1'b1;
				state_d = msdc_pkg::S_MARK_C;
			end
			msdc_pkg::S_MARK_C: begin
				uwe     = 1'b1;
				uwa     = tri_q[2*FW +: VA];
				uwd     = 1'b1;
				i_d     = i_q + (TCW+1)'(step_q);
				state_d = msdc_pkg::S_WALK_RD;
			end
			msdc_pkg::S_REMAP: begin
				// issue the next vertex, retire the one read last cycle
				if (v_q < vt_q) begin
					ura      = v_q[VA-1:0];
					vra      = v_q[VA-1:0];
					rm_vld_d = 1'b1;
					v_d      = v_q + VCW'(1);
				end
				if (rm_vld_s1 && urd_q) begin
					rwe  = 1'b1;
					rwa  = rm_v_s1;
					rwd  = kv_q[VA-1:0];
					vwe  = 1'b1;
					vwa  = kv_q[VA-1:0];
					vwd  = vrd_q;
					kv_d = kv_q + VCW'(1);
				end
				if (v_q >= vt_q && !rm_vld_s1) begin
					phase_d = msdc_pkg::PH_DONE;
					rp_d    = '0;
					pend_d  = '0;
					pend_d.out_kind       = msdc_pkg::RK_STATUS;
					pend_d.status         = ovf_q ? msdc_pkg::STAT_OVERFLOW
						: msdc_pkg::STAT_OK;
					pend_d.kept_vertices  = 13'(kv_q);
					pend_d.kept_triangles = 13'(kt_q);
					state_d = msdc_pkg::S_EMIT;
				end
			end
			msdc_pkg::S_VTX: begin
				pend_d.out_kind = msdc_pkg::RK_VERTEX;
				pend_d.out_x    = vrd_q[95:64];
				pend_d.out_y    = vrd_q[63:32];
				pend_d.out_z    = vrd_q[31:0];
				pend_d.last     = (last_w == total_w);
				rp_d            = last_w;
				state_d         = msdc_pkg::S_EMIT;
			end
			msdc_pkg::S_TRI: begin
				tri_d   = trd_q;
				rra     = trd_q[0 +: VA];
				state_d = msdc_pkg::S_MAP_A;
			end
			msdc_pkg::S_MAP_A: begin
				pend_d.out_kind = msdc_pkg::RK_TRIANGLE;
				pend_d.out_a    = 12'(rrd_q);
				rra             = tri_q[FW +: VA];
				state_d         = msdc_pkg::S_MAP_B;
			end
			msdc_pkg::S_MAP_B: begin
				pend_d.out_b = 12'(rrd_q);
				rra          = tri_q[2*FW +: VA];
				state_d      = msdc_pkg::S_MAP_C;
			end
			msdc_pkg::S_MAP_C: begin
				pend_d.out_c = 12'(rrd_q);
				pend_d.last  = (last_w == total_w);
				rp_d         = last_w;
				state_d      = msdc_pkg::S_EMIT;
			end
			msdc_pkg::S_EMIT: begin
				// hold until the result register is free
				if (out_load)
					state_d = msdc_pkg::S_IDLE;
			end
			default: state_d = msdc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msdc_pkg::S_IDLE;
			phase_q     <= msdc_pkg::PH_LOADING;
			vt_q        <= '0;
			tt_q        <= '0;
			kv_q        <= '0;
			kt_q        <= '0;
			v_q         <= '0;
			i_q         <= '0;
			rp_q        <= '0;
			ovf_q       <= 1'b0;
			ratio_q     <= msdc_pkg::RATIO_ONE;
			rm_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			vt_q      <= vt_d;
			tt_q      <= tt_d;
			kv_q      <= kv_d;
			kt_q      <= kt_d;
			v_q       <= v_d;
			i_q       <= i_d;
			rp_q      <= rp_d;
			ovf_q     <= ovf_d;
			rm_vld_s1 <= rm_vld_d;
			if (cfg_valid)
				ratio_q <= cfg_data;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		pend_q   <= pend_d;
		tri_q    <= tri_d;
		target_q <= target_d;
		step_q   <= step_d;
		rm_v_s1  <= v_q[VA-1:0];
		if (out_load)
			out_q <= pend_q;
	end

	// never overwrite a result the receiver has not taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(out_valid_q && result_stall))
		else $error("result register overwritten while stalled");

	// in-place vertex compaction writes at or below the entry being retired
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msdc_pkg::S_REMAP && rm_vld_s1) |-> (VCW'(rm_v_s1) >= kv_q))
		else $error("vertex compaction overtook its source");

	// kept triangles never outnumber loaded ones
	assert property (@(posedge clk) disable iff (!arst_n)
		kt_q <= tt_q)
		else $error("kept triangle count exceeds loaded count");

	// read pointer stays within the stream once decimated
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == msdc_pkg::PH_DONE) |-> (rp_q <= total_w))
		else $error("read pointer past end of stream");

endmodule

// ----- tb/mesh_stride_decimate_compact_tb.sv -----
// Self-checking testbench of the stride mesh decimator.
// Needs msdc_pkg and mesh_stride_decimate_compact; predicts every result
// in its own mesh model and checks results in order, field by field.
`timescale 1ns / 1ps

module mesh_stride_decimate_compact_tb;

	localparam int CAP        = 4096;
	localparam int IDLE_LIMIT = 200000;
	localparam int HOLD_LEN   = 400;
	localparam int ITEM_GOAL  = 850;

	typedef struct {
		msdc_pkg::item_t it;
		bit    burst;
	} pending_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	msdc_pkg::item_t   item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	msdc_pkg::result_t result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data = '0;
	logic        hold_req = 1'b0;
	bit          hold_done = 1'b0;

	pending_t pending_items[$];
	msdc_pkg::result_t expected_results[$];
	int       error_count = 0;
	int       random_items = 0;

	// mesh model state
	logic [31:0] vtx_x [0:CAP-1];
	logic [31:0] vtx_y [0:CAP-1];
	logic [31:0] vtx_z [0:CAP-1];
	logic [31:0] tri_a [0:CAP-1];
	logic [31:0] tri_b [0:CAP-1];
	logic [31:0] tri_c [0:CAP-1];
	bit          used_vtx [0:CAP-1];
	logic [11:0] remap_idx [0:CAP-1];
	int unsigned kept_list [0:CAP-1];
	int unsigned vtx_count, tri_count, kept_vtx, kept_tri, fetch_ptr;
	bit          overflowed;
	msdc_pkg::phase_t mesh_phase = msdc_pkg::PH_LOADING;
	int unsigned ratio_q = 65536;

	mesh_stride_decimate_compact u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Start a fresh mesh when a load follows a finish.
	function automatic void restart_mesh();
		if (mesh_phase != msdc_pkg::PH_LOADING) begin
			vtx_count = 0;
			tri_count = 0;
			kept_vtx = 0;
			kept_tri = 0;
			fetch_ptr = 0;
			overflowed = 0;
			mesh_phase = msdc_pkg::PH_LOADING;
		end
	endfunction

	// Pick every step-th triangle with valid indices, then compact vertices.
	function automatic void decimate_mesh();
		longint unsigned r, target, step;
		int unsigned k, n;
		r = (ratio_q > 65536) ? 65536 : ratio_q;
		target = (longint'(tri_count) * r) >> 16;
		if (target < 1) target = 1;
		step = tri_count / target;
		if (step < 1) step = 1;
		k = 0;
		n = 0;
		for (int v = 0; v < CAP; v++) used_vtx[v] = 0;
		for (longint unsigned i = 0; i < tri_count; i += step) begin
			if (tri_a[i] < vtx_count && tri_b[i] < vtx_count && tri_c[i] < vtx_count) begin
				used_vtx[tri_a[i]] = 1;
				used_vtx[tri_b[i]] = 1;
				used_vtx[tri_c[i]] = 1;
				// compact in place; k never passes i
				tri_a[k] = tri_a[i];
				tri_b[k] = tri_b[i];
				tri_c[k] = tri_c[i];
				k++;
			end
		end
		for (int unsigned v = 0; v < vtx_count; v++) begin
			if (used_vtx[v]) begin
				remap_idx[v] = n[11:0];
				kept_list[n] = v;
				n++;
			end
		end
		kept_vtx = n;
		kept_tri = k;
		mesh_phase = msdc_pkg::PH_DONE;
		fetch_ptr = 0;
	endfunction

	// Advance the mesh model by one accepted transaction; queue its result, if any.
	function automatic void mesh_predict(msdc_pkg::item_t it);
		msdc_pkg::result_t r;
		int unsigned total, t;
		r = '0;
		case (it.kind)
			msdc_pkg::KIND_VERTEX: begin
				restart_mesh();
				if (vtx_count >= CAP) overflowed = 1;
				else begin
					vtx_x[vtx_count] = it.coord_x;
					vtx_y[vtx_count] = it.coord_y;
					vtx_z[vtx_count] = it.coord_z;
					vtx_count++;
				end
				return;
			end
			msdc_pkg::KIND_TRIANGLE: begin
				restart_mesh();
				if (tri_count >= CAP) overflowed = 1;
				else begin
					tri_a[tri_count] = it.index_a;
					tri_b[tri_count] = it.index_b;
					tri_c[tri_count] = it.index_c;
					tri_count++;
				end
				return;
			end
			msdc_pkg::KIND_FINISH: begin
				if (mesh_phase == msdc_pkg::PH_LOADING) decimate_mesh();
				else fetch_ptr = 0;
				r.out_kind = msdc_pkg::RK_STATUS;
				r.status = overflowed ? msdc_pkg::STAT_OVERFLOW : msdc_pkg::STAT_OK;
				r.kept_vertices = kept_vtx[12:0];
				r.kept_triangles = kept_tri[12:0];
			end
			default: begin
				total = kept_vtx + kept_tri;
				if (mesh_phase != msdc_pkg::PH_DONE || fetch_ptr >= total) begin
					r.out_kind = msdc_pkg::RK_STATUS;
					r.status = msdc_pkg::STAT_EMPTY;
				end else begin
					if (fetch_ptr < kept_vtx) begin
						r.out_kind = msdc_pkg::RK_VERTEX;
						r.out_x = vtx_x[kept_list[fetch_ptr]];
						r.out_y = vtx_y[kept_list[fetch_ptr]];
						r.out_z = vtx_z[kept_list[fetch_ptr]];
					end else begin
						t = fetch_ptr - kept_vtx;
						r.out_kind = msdc_pkg::RK_TRIANGLE;
						r.out_a = remap_idx[tri_a[t][11:0]];
						r.out_b = remap_idx[tri_b[t][11:0]];
						r.out_c = remap_idx[tri_c[t][11:0]];
					end
					r.last = (fetch_ptr + 1 == total);
					fetch_ptr++;
				end
			end
		endcase
		expected_results.insert(expected_results.size(), r);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		error_count++;
	endtask

	// Sender: pop pending transactions, wait a drawn gap between them.
	int  send_gap = 0;
	bit  send_quiet = 0;
	bit  cur_burst = 0;
	always @(posedge clk or negedge arst_n) begin
		pending_t e;
		bit take;
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_gap = 0;
		end else begin
			take = item_valid && !item_stall;
			if (take) begin
				mesh_predict(item);
				if ($urandom_range(0, 49) == 0) send_quiet = !send_quiet;
				send_gap = (cur_burst || send_quiet) ? 0 : $urandom_range(0, 13);
			end
			if (!item_valid || take) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					e = pending_items.pop_front();
					item <= e.it;
					cur_burst = e.burst;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result against the oldest expectation; stall at random.
	int  recv_gap = 0;
	bit  recv_quiet = 0;
	always @(posedge clk) begin
		msdc_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result kind", 32'(result.out_kind), '0);
			end else begin
				want = expected_results.pop_front();
				if (result.out_kind != want.out_kind)
					report_mismatch("out_kind", 32'(result.out_kind), 32'(want.out_kind));
				if (result.out_x != want.out_x) report_mismatch("out_x", result.out_x, want.out_x);
				if (result.out_y != want.out_y) report_mismatch("out_y", result.out_y, want.out_y);
				if (result.out_z != want.out_z) report_mismatch("out_z", result.out_z, want.out_z);
				if (result.out_a != want.out_a)
					report_mismatch("out_a", 32'(result.out_a), 32'(want.out_a));
				if (result.out_b != want.out_b)
					report_mismatch("out_b", 32'(result.out_b), 32'(want.out_b));
				if (result.out_c != want.out_c)
					report_mismatch("out_c", 32'(result.out_c), 32'(want.out_c));
				if (result.last != want.last)
					report_mismatch("last", 32'(result.last), 32'(want.last));
				if (result.status != want.status)
					report_mismatch("status", 32'(result.status), 32'(want.status));
				if (result.kept_vertices != want.kept_vertices)
					report_mismatch("kept_vertices", 32'(result.kept_vertices),
						32'(want.kept_vertices));
				if (result.kept_triangles != want.kept_triangles)
					report_mismatch("kept_triangles", 32'(result.kept_triangles),
						32'(want.kept_triangles));
			end
			if ($urandom_range(0, 49) == 0) recv_quiet = !recv_quiet;
			recv_gap = recv_quiet ? 0 : $urandom_range(0, 13);
		end
		// long hold-off: let the block back up into its input
		if (hold_req && !hold_done) begin
			recv_gap = HOLD_LEN;
			hold_done = 1'b1;
		end
		result_stall <= (recv_gap > 0);
		if (recv_gap > 0) recv_gap--;
	end

	// Watchdog: count cycles without any transaction.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic push_item(logic [1:0] kind, logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] a, logic [31:0] b, logic [31:0] c, bit burst = 0);
		pending_t e;
		e.it = '{kind: kind, coord_x: x, coord_y: y, coord_z: z, index_a: a, index_b: b,
			index_c: c};
		e.burst = burst;
		pending_items.insert(pending_items.size(), e);
	endtask

	task automatic push_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit burst = 0);
		push_item(msdc_pkg::KIND_VERTEX, x, y, z, $urandom, $urandom, $urandom, burst);
	endtask

	task automatic push_triangle(logic [31:0] a, logic [31:0] b, logic [31:0] c, bit burst = 0);
		push_item(msdc_pkg::KIND_TRIANGLE, $urandom, $urandom, $urandom, a, b, c, burst);
	endtask

	task automatic push_cmd(logic [1:0] kind);
		push_item(kind, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Hold until the block has drained, then allow for loads still in flight.
	task automatic wait_idle();
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_ratio(logic [16:0] value);
		wait_idle();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		ratio_q = value;
		cfg_valid <= 1'b0;
	endtask

	// Index mostly in range; sometimes just past the end or anywhere.
	function automatic logic [31:0] pick_index(int unsigned nv);
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (nv != 0 && sel < 8) return $urandom_range(0, nv - 1);
		if (sel == 8) return nv;
		return $urandom;
	endfunction

	task automatic random_mesh();
		int unsigned nv, nt, lv, lt, nfetch;
		nv = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 24);
		nt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 32);
		lv = 0;
		lt = 0;
		while (lv < nv || lt < nt) begin
			if (lt >= nt || (lv < nv && $urandom_range(0, 1))) begin
				push_vertex($urandom, $urandom, $urandom);
				lv++;
			end else begin
				push_triangle(pick_index(nv), pick_index(nv), pick_index(nv));
				lt++;
			end
			if ($urandom_range(0, 39) == 0) begin
				push_cmd(2'($urandom_range(0, 3)));
				random_items++;
			end
		end
		random_items += nv + nt;
		if ($urandom_range(0, 7) == 0) begin
			push_cmd(msdc_pkg::KIND_FETCH);
			random_items++;
		end
		push_cmd(msdc_pkg::KIND_FINISH);
		nfetch = $urandom_range(0, 3) == 0 ? $urandom_range(0, nv + nt)
			: nv + nt + $urandom_range(0, 2);
		for (int i = 0; i < nfetch; i++) push_cmd(msdc_pkg::KIND_FETCH);
		random_items += nfetch + 1;
		if ($urandom_range(0, 3) == 0) begin
			push_cmd(msdc_pkg::KIND_FINISH);
			for (int i = 0; i < 4; i++) push_cmd(msdc_pkg::KIND_FETCH);
			random_items += 5;
		end
	endtask

	initial begin
		logic [16:0] ratio_pick [6];
		int mesh_no;
		ratio_pick = '{17'd0, 17'd1, 17'd65535, 17'd65536, 17'h1FFFF, 17'd32768};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty mesh, fetch before finish, extreme fields.
		write_ratio(msdc_pkg::RATIO_ONE);
		push_cmd(msdc_pkg::KIND_FETCH);
		push_cmd(msdc_pkg::KIND_FINISH);
		push_cmd(msdc_pkg::KIND_FETCH);
		push_vertex('0, '0, '0);
		push_vertex('1, '1, '1);
		push_vertex(32'h7F80_0000, 32'h8000_0000, 32'h3F80_0000);
		push_triangle(0, 1, 2);
		push_triangle(2, 1, 0);
		push_triangle(0, 3, 1);
		push_triangle('1, 0, 0);
		push_triangle(1, 1, 1);
		push_cmd(msdc_pkg::KIND_FINISH);
		for (int i = 0; i < 3; i++) push_cmd(msdc_pkg::KIND_FETCH);
		push_cmd(msdc_pkg::KIND_FINISH);
		for (int i = 0; i < 8; i++) push_cmd(msdc_pkg::KIND_FETCH);

		// Ratio zero and saturating ratio on a small mesh.
		for (int s = 0; s < 2; s++) begin
			write_ratio(s == 0 ? 17'd0 : 17'h1FFFF);
			for (int i = 0; i < 4; i++) push_vertex($urandom, $urandom, $urandom);
			for (int i = 0; i < 6; i++) push_triangle(i % 4, (i + 1) % 4, (i + 2) % 4);
			push_cmd(msdc_pkg::KIND_FINISH);
			for (int i = 0; i < 8; i++) push_cmd(msdc_pkg::KIND_FETCH);
		end

		// Random meshes; change the ratio between some of them.
		mesh_no = 0;
		while (random_items < ITEM_GOAL) begin
			if (mesh_no % 3 == 2) begin
				if ($urandom_range(0, 1)) write_ratio(ratio_pick[$urandom_range(0, 5)]);
				else write_ratio(17'($urandom_range(1, 65536)));
			end
			if (mesh_no == 4) begin
				wait_idle();
				hold_req <= 1'b1;
			end
			random_mesh();
			mesh_no++;
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/msdc_pkg.sv
rtl/msdc_divider.sv
rtl/mesh_stride_decimate_compact.sv
tb/mesh_stride_decimate_compact_tb.sv
